// ===== hw/rtl/vssp_pkg.sv =====
// ----------------------------------------------------------------------------
// vssp_pkg: shared types and constants of the variable speed sample player
// Widths, fixed-point constants, codes and small helper functions used by
// the player's modules and channel interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package vssp_pkg;

  // Sample store geometry (a power of two, 4 to 1048576 frames)
  localparam int STORE_FRAMES  = 65536;
  localparam int STORE_ADDR_W  = $clog2(STORE_FRAMES);
  localparam int FRACTION_BITS = 11;

  // Field widths
  localparam int SAMPLE_W = 16;
  localparam int FRAME_W  = 2 * SAMPLE_W;
  localparam int SPEED_W  = 16;
  localparam int RATIO_W  = 16;
  localparam int SPAN_W   = 16;
  localparam int LOOP_W   = 8;
  localparam int FADDR_W  = 16;
  localparam int CNT_W    = 7;

  // Playhead and derived widths
  localparam int PH_W     = 29;
  localparam int STEP_W   = 19;
  localparam int LEN_W    = SPAN_W + FRACTION_BITS;
  localparam int WHOLE_W  = PH_W - 1 - FRACTION_BITS;
  localparam int PROD_W   = 32;
  localparam int TERM_W   = SAMPLE_W + FRACTION_BITS + 1;

  // Fixed-point constants
  localparam logic signed [SPEED_W:0]   SPEED_LIMIT   = 17'sd20480;
  localparam logic [CNT_W-1:0]          SMOOTH_PERIOD = 7'd64;
  localparam logic [15:0]               RECIP_TENTH   = 16'd52429;
  localparam int                        RECIP_SHIFT   = 19;
  localparam int                        STEP_SHIFT    = 13;
  localparam logic [FRACTION_BITS-1:0]  FRAC_MAX      = 11'd2047;

  // Configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    REG_SPAN    = 2'd0,
    REG_RATIO   = 2'd1,
    REG_LOOP    = 2'd2,
    REG_PLAYING = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_SET   = 2'd1,
    MODE_NUDGE = 2'd2,
    MODE_TICK  = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SMOOTH_MUL,
    S_SMOOTH_ADD,
    S_STEP_MUL,
    S_ENDS,
    S_DIV,
    S_RD0,
    S_RD1,
    S_MUL,
    S_SUM
  } state_t;

  typedef struct packed {
    logic [SPAN_W-1:0]  span_frames;
    logic [RATIO_W-1:0] rate_ratio;
    logic [LOOP_W-1:0]  loop_limit;
    logic               playing;
  } cfg_t;

  typedef struct packed {
    logic               start;
    logic [WHOLE_W-1:0] dividend;
    logic [SPAN_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [SPAN_W-1:0] rem;
  } div_rsp_t;

  // Clamp a speed to plus or minus 5.0 in Q3.12
  function automatic logic signed [SPEED_W-1:0] clamp_speed(input logic signed [SPEED_W:0] v);
    logic signed [SPEED_W:0] r;
    r = v;
    if (v < -SPEED_LIMIT) r = -SPEED_LIMIT;
    if (v > SPEED_LIMIT)  r = SPEED_LIMIT;
    return SPEED_W'(r);
  endfunction

  // Reduce a frame index to a store address
  function automatic logic [STORE_ADDR_W-1:0] store_index(input logic [WHOLE_W-1:0] v);
    logic [31:0] ext;
    ext = 32'(v);
    return ext[STORE_ADDR_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/vssp_in_if.sv =====
// ----------------------------------------------------------------------------
// vssp_in_if: input item channel of the sample player
// Valid/ready channel carrying one command item.
// ----------------------------------------------------------------------------
`default_nettype none

interface vssp_in_if import vssp_pkg::*;;
  logic                       valid;
  logic                       ready;
  mode_t                      mode;
  logic [FADDR_W-1:0]         frame_address;
  logic signed [SAMPLE_W-1:0] left_in;
  logic signed [SAMPLE_W-1:0] right_in;
  logic signed [SPEED_W-1:0]  speed_value;

  modport source (output valid, mode, frame_address, left_in, right_in, speed_value,
                  input ready);
  modport sink   (input valid, mode, frame_address, left_in, right_in, speed_value,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/vssp_out_if.sv =====
// ----------------------------------------------------------------------------
// vssp_out_if: result item channel of the sample player
// Valid/ready channel carrying one interpolated stereo frame.
// ----------------------------------------------------------------------------
`default_nettype none

interface vssp_out_if import vssp_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_out;
  logic signed [SAMPLE_W-1:0] right_out;
  logic [SPAN_W-1:0]          play_frame;
  logic [LOOP_W-1:0]          loop_count;

  modport source (output valid, left_out, right_out, play_frame, loop_count, input ready);
  modport sink   (input valid, left_out, right_out, play_frame, loop_count, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/vssp_ram.sv =====
// ----------------------------------------------------------------------------
// vssp_ram: generic single-port RAM
// One read or write per cycle, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module vssp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable, register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/vssp_rem_div.sv =====
// ----------------------------------------------------------------------------
// vssp_rem_div: iterative remainder unit
// Restoring division, one dividend bit per cycle; gives the remainder of a
// whole-frame count by the span.
// ----------------------------------------------------------------------------
`default_nettype none

module vssp_rem_div import vssp_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  localparam int DCNT_W = $clog2(WHOLE_W + 1);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [DCNT_W-1:0]   cnt_r, cnt_nxt;
  logic [WHOLE_W-1:0]  quo_r, quo_nxt;
  logic [SPAN_W-1:0]   rem_r, rem_nxt;
  logic [SPAN_W-1:0]   div_r, div_nxt;
  logic [SPAN_W:0]     trial;

  // Shift one bit in, subtract where it fits
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    trial    = {rem_r, quo_r[WHOLE_W-1]};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DCNT_W'(WHOLE_W);
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      div_nxt  = req.divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[WHOLE_W-2:0], 1'b0};
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = SPAN_W'(trial - {1'b0, div_r});
      end else begin
        rem_nxt = trial[SPAN_W-1:0];
      end
      cnt_nxt = cnt_r - DCNT_W'(1);
      if (cnt_r == DCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

  // A finished remainder is below the divisor
  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rem_r < div_r))
    else $error("remainder not below divisor");

  // No restart while a division runs
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("division restarted while busy");

endmodule

`default_nettype wire

// ===== hw/rtl/vssp_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// vssp_cfg_regs: configuration registers of the sample player
// APB-style write and read of span, rate ratio, loop limit and play flag.
// ----------------------------------------------------------------------------
`default_nettype none

module vssp_cfg_regs import vssp_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg
);

  cfg_t     cfg_r, cfg_nxt;
  reg_idx_t idx;
  logic     wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite && pready;

  // Update the addressed register on a completed write
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (idx)
        REG_SPAN:    cfg_nxt.span_frames = pwdata[SPAN_W-1:0];
        REG_RATIO:   cfg_nxt.rate_ratio  = pwdata[RATIO_W-1:0];
        REG_LOOP:    cfg_nxt.loop_limit  = pwdata[LOOP_W-1:0];
        REG_PLAYING: cfg_nxt.playing     = pwdata[0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (idx)
      REG_SPAN:    prdata = CFG_DATA_W'(cfg_r.span_frames);
      REG_RATIO:   prdata = CFG_DATA_W'(cfg_r.rate_ratio);
      REG_LOOP:    prdata = CFG_DATA_W'(cfg_r.loop_limit);
      REG_PLAYING: prdata = CFG_DATA_W'(cfg_r.playing);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.span_frames <= 16'd65534;
      cfg_r.rate_ratio  <= 16'd4096;
      cfg_r.loop_limit  <= 8'd1;
      cfg_r.playing     <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== hw/rtl/variable_speed_sample_player_unit.sv =====
// ----------------------------------------------------------------------------
// variable_speed_sample_player_unit: stereo sample player with variable speed
// Linear-interpolating playback from a frame store, with speed easing and
// wrap, loop and hold handling of the playhead.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan takes one item per handshake: load a frame into the store, set or
//   nudge the target speed, or tick. A load, set or nudge keeps the
//   sequencer idle. A tick while playing gives one item on out_chan; a tick
//   while stopped keeps the sequencer idle and gives nothing.
//   A tick runs through a sequencer around one single-port frame store:
//   step multiply, ends check, two store reads, weighting multiply and
//   sum into the output register; on every 65th tick a speed easing
//   multiply and add come first, and when the playhead crosses an end and
//   wraps, a wait on the 17-step remainder unit follows the ends check.
//   The two store reads fetch the neighboring frames.
//   in_chan.ready is high only while the sequencer is idle.
//   The result sits in an output register; the next item is taken while it
//   waits. A tick that finishes while the earlier result is still untaken
//   holds in its last step until out_chan.ready. The user is to write
//   configuration through the APB port while the block is idle; not enforced.
//   Reset (rst_n low, synchronous) clears playhead, pass number, speeds and
//   counters and loads the register defaults; the store keeps its contents
//   and needs no clearing pass if the user loads entries before they are
//   played; the block does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module variable_speed_sample_player_unit import vssp_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  vssp_in_if.sink                    in_chan,
  vssp_out_if.source                 out_chan,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int QUO_W = PROD_W - RECIP_SHIFT;
  localparam int SUM_W = TERM_W + 1;

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  state_t state_r, state_nxt;

  logic signed [PH_W-1:0]    ph_r, ph_nxt;
  logic [LOOP_W-1:0]         pass_r, pass_nxt;
  logic signed [SPEED_W-1:0] cur_r, cur_nxt;
  logic signed [SPEED_W-1:0] tgt_r, tgt_nxt;
  logic signed [STEP_W-1:0]  step_r, step_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      out_valid_r, out_valid_nxt;

  logic [PROD_W-1:0]         prod_r, prod_nxt;
  logic                      neg_r, neg_nxt;
  logic                      div_neg_r, div_neg_nxt;
  logic [FRACTION_BITS-1:0]  frac_r, frac_nxt;
  logic [FRAME_W-1:0]        w0_r, w0_nxt;
  logic signed [TERM_W-1:0]  pl0_r, pl1_r, pr0_r, pr1_r;
  logic signed [TERM_W-1:0]  pl0_nxt, pl1_nxt, pr0_nxt, pr1_nxt;

  logic signed [SAMPLE_W-1:0] left_r, left_nxt;
  logic signed [SAMPLE_W-1:0] right_r, right_nxt;
  logic [SPAN_W-1:0]          frame_r, frame_nxt;
  logic [LOOP_W-1:0]          loop_r, loop_nxt;

  logic                      ram_we;
  logic [STORE_ADDR_W-1:0]   ram_addr;
  logic [FRAME_W-1:0]        ram_wdata;
  logic [FRAME_W-1:0]        ram_rdata;

  logic                      accept;
  logic [SPAN_W-1:0]         span_eff;
  logic [LEN_W-1:0]          len;
  logic [LEN_W-1:0]          len_m1;
  logic                      ph_ge_len;
  logic [PH_W-1:0]           ph_neg;
  logic [SPAN_W-1:0]         p_whole;
  logic [LEN_W-1:0]          wrapped;
  logic [LOOP_W-1:0]         pass_inc;
  logic signed [SPEED_W:0]   nudge_sum;
  logic signed [SPEED_W:0]   diff;
  logic [SPEED_W-1:0]        diff_mag;
  logic [SPEED_W-1:0]        cur_mag;
  logic signed [SPEED_W:0]   quo_s;
  logic signed [SPEED_W:0]   speed_sum;
  logic [STEP_W-1:0]         step_mag;
  logic [FRACTION_BITS-1:0]  wt0, wt1;
  logic signed [SUM_W-1:0]   sum_l, sum_r;

  vssp_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  vssp_rem_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  vssp_ram #(
    .WIDTH (FRAME_W),
    .DEPTH (STORE_FRAMES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Derived limits of the playhead
  assign span_eff  = (cfg.span_frames == '0) ? SPAN_W'(1) : cfg.span_frames;
  assign len       = {span_eff, {FRACTION_BITS{1'b0}}};
  assign len_m1    = len - LEN_W'(1);
  assign ph_ge_len = !ph_r[PH_W-1] && (ph_r[PH_W-2:0] >= (PH_W-1)'(len));
  assign ph_neg    = PH_W'(-ph_r);
  assign p_whole   = ph_r[LEN_W-1:FRACTION_BITS];
  assign wrapped   = {div_rsp.rem, frac_r};
  assign pass_inc  = pass_r + LOOP_W'(1);

  // Speed arithmetic terms
  assign nudge_sum = (SPEED_W+1)'(tgt_r) + (SPEED_W+1)'(in_chan.speed_value);
  assign diff      = (SPEED_W+1)'(tgt_r) - (SPEED_W+1)'(cur_r);
  assign diff_mag  = diff[SPEED_W] ? SPEED_W'(-diff) : SPEED_W'(diff);
  assign cur_mag   = cur_r[SPEED_W-1] ? SPEED_W'(-cur_r) : SPEED_W'(cur_r);
  assign quo_s     = $signed({{(SPEED_W+1-QUO_W){1'b0}}, prod_r[PROD_W-1:RECIP_SHIFT]});
  assign speed_sum = neg_r ? ((SPEED_W+1)'(cur_r) - quo_s) : ((SPEED_W+1)'(cur_r) + quo_s);
  assign step_mag  = prod_r[STEP_SHIFT+STEP_W-1:STEP_SHIFT];

  // Interpolation weights and sums
  assign wt1   = ph_r[FRACTION_BITS-1:0];
  assign wt0   = FRAC_MAX - wt1;
  assign sum_l = SUM_W'(pl0_r) + SUM_W'(pl1_r);
  assign sum_r = SUM_W'(pr0_r) + SUM_W'(pr1_r);

  assign accept = in_chan.valid && in_chan.ready;

  // Sequencer: next state, datapath updates and store port
  always_comb begin
    state_nxt     = state_r;
    ph_nxt        = ph_r;
    pass_nxt      = pass_r;
    cur_nxt       = cur_r;
    tgt_nxt       = tgt_r;
    step_nxt      = step_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    prod_nxt      = prod_r;
    neg_nxt       = neg_r;
    div_neg_nxt   = div_neg_r;
    frac_nxt      = frac_r;
    w0_nxt        = w0_r;
    pl0_nxt       = pl0_r;
    pl1_nxt       = pl1_r;
    pr0_nxt       = pr0_r;
    pr1_nxt       = pr1_r;
    left_nxt      = left_r;
    right_nxt     = right_r;
    frame_nxt     = frame_r;
    loop_nxt      = loop_r;
    div_req.start    = 1'b0;
    div_req.dividend = ph_r[PH_W-2:FRACTION_BITS];
    div_req.divisor  = span_eff;
    ram_we    = 1'b0;
    ram_addr  = store_index({1'b0, in_chan.frame_address});
    ram_wdata = {in_chan.right_in, in_chan.left_in};
    in_chan.ready = (state_r == S_IDLE);

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_chan.mode)
            MODE_LOAD: begin
              ram_we = 1'b1;
            end
            MODE_SET: begin
              tgt_nxt = clamp_speed((SPEED_W+1)'(in_chan.speed_value));
            end
            MODE_NUDGE: begin
              if ((in_chan.speed_value > -SPEED_LIMIT) &&
                  (in_chan.speed_value < SPEED_LIMIT)) begin
                tgt_nxt = SPEED_W'(nudge_sum >>> 1);
              end
            end
            MODE_TICK: begin
              if (cfg.playing) begin
                if (cnt_r == SMOOTH_PERIOD) begin
                  cnt_nxt   = '0;
                  state_nxt = S_SMOOTH_MUL;
                end else begin
                  cnt_nxt   = cnt_r + CNT_W'(1);
                  state_nxt = S_STEP_MUL;
                end
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      // Tenth of the speed gap via reciprocal multiply
      S_SMOOTH_MUL: begin
        neg_nxt   = diff[SPEED_W];
        prod_nxt  = diff_mag * RECIP_TENTH;
        state_nxt = S_SMOOTH_ADD;
      end

      S_SMOOTH_ADD: begin
        cur_nxt   = clamp_speed(speed_sum);
        state_nxt = S_STEP_MUL;
      end

      // Step magnitude from speed and rate ratio
      S_STEP_MUL: begin
        neg_nxt   = cur_r[SPEED_W-1];
        prod_nxt  = cur_mag * cfg.rate_ratio;
        state_nxt = S_ENDS;
      end

      // Apply the sign to the step, handle the ends of the playhead
      S_ENDS: begin
        step_nxt  = neg_r ? STEP_W'(-step_mag) : step_mag;
        state_nxt = S_RD0;
        if (ph_ge_len) begin
          if (pass_r >= cfg.loop_limit) begin
            ph_nxt = PH_W'({2'b00, len_m1});
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = ph_r[PH_W-2:FRACTION_BITS];
            div_neg_nxt      = 1'b0;
            frac_nxt         = ph_r[FRACTION_BITS-1:0];
            state_nxt        = S_DIV;
          end
        end else if (ph_r[PH_W-1]) begin
          if (pass_r == '0) begin
            ph_nxt = '0;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = ph_neg[PH_W-2:FRACTION_BITS];
            div_neg_nxt      = 1'b1;
            frac_nxt         = ph_neg[FRACTION_BITS-1:0];
            state_nxt        = S_DIV;
          end
        end
      end

      // Wait for the remainder, then wrap forward or backward
      S_DIV: begin
        if (div_rsp.done) begin
          if (div_neg_r) begin
            ph_nxt   = PH_W'({2'b00, len_m1 - wrapped});
            pass_nxt = pass_r - LOOP_W'(1);
          end else begin
            ph_nxt   = PH_W'({2'b00, wrapped});
            pass_nxt = (pass_inc >= cfg.loop_limit) ? '0 : pass_inc;
          end
          state_nxt = S_RD0;
        end
      end

      S_RD0: begin
        ram_addr  = store_index({1'b0, p_whole});
        state_nxt = S_RD1;
      end

      S_RD1: begin
        ram_addr  = store_index({1'b0, p_whole} + WHOLE_W'(1));
        w0_nxt    = ram_rdata;
        state_nxt = S_MUL;
      end

      // Weighted terms of both channels
      S_MUL: begin
        pl0_nxt   = $signed(w0_r[SAMPLE_W-1:0])            * $signed({1'b0, wt0});
        pl1_nxt   = $signed(ram_rdata[SAMPLE_W-1:0])       * $signed({1'b0, wt1});
        pr0_nxt   = $signed(w0_r[FRAME_W-1:SAMPLE_W])      * $signed({1'b0, wt0});
        pr1_nxt   = $signed(ram_rdata[FRAME_W-1:SAMPLE_W]) * $signed({1'b0, wt1});
        state_nxt = S_SUM;
      end

      // Deliver once the output register is free, then advance the head
      S_SUM: begin
        if (!out_valid_r || out_chan.ready) begin
          left_nxt      = sum_l[FRACTION_BITS+SAMPLE_W-1:FRACTION_BITS];
          right_nxt     = sum_r[FRACTION_BITS+SAMPLE_W-1:FRACTION_BITS];
          frame_nxt     = p_whole;
          loop_nxt      = pass_r;
          out_valid_nxt = 1'b1;
          ph_nxt        = ph_r + PH_W'(step_r);
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ph_r        <= '0;
      pass_r      <= '0;
      cur_r       <= '0;
      tgt_r       <= '0;
      step_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      neg_r       <= 1'b0;
      div_neg_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ph_r        <= ph_nxt;
      pass_r      <= pass_nxt;
      cur_r       <= cur_nxt;
      tgt_r       <= tgt_nxt;
      step_r      <= step_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      neg_r       <= neg_nxt;
      div_neg_r   <= div_neg_nxt;
    end
    prod_r  <= prod_nxt;
    frac_r  <= frac_nxt;
    w0_r    <= w0_nxt;
    pl0_r   <= pl0_nxt;
    pl1_r   <= pl1_nxt;
    pr0_r   <= pr0_nxt;
    pr1_r   <= pr1_nxt;
    left_r  <= left_nxt;
    right_r <= right_nxt;
    frame_r <= frame_nxt;
    loop_r  <= loop_nxt;
  end

  // Drive the result channel from the output register
  assign out_chan.valid      = out_valid_r;
  assign out_chan.left_out   = left_r;
  assign out_chan.right_out  = right_r;
  assign out_chan.play_frame = frame_r;
  assign out_chan.loop_count = loop_r;

  // Playhead lies inside the span when the store is read
  a_head_in_span: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD0) |-> (!ph_r[PH_W-1] && (ph_r[PH_W-2:0] < (PH_W-1)'(len))))
    else $error("playhead outside span at store read");

  // Current speed stays within plus or minus 5.0
  a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_r >= -SPEED_LIMIT) && (cur_r <= SPEED_LIMIT))
    else $error("current speed out of range");

  // Store writes come only from loads taken in idle
  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> ((state_r == S_IDLE) && accept))
    else $error("store write outside idle");

  // A remainder only arrives while the sequencer waits for it
  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIV))
    else $error("remainder arrived outside wrap step");

endmodule

`default_nettype wire
